// ===== rtl/priority_bucketed_waiter_queue_defines.svh =====
// Assertion macros for the priority bucketed waiter queue.
// Used by pbwq_ctrl and pbwq_dp; expects i_clk and i_rst_n in scope.
`ifndef PRIORITY_BUCKETED_WAITER_QUEUE_DEFINES_SVH
`define PRIORITY_BUCKETED_WAITER_QUEUE_DEFINES_SVH

// same-cycle implication
`define PBWQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pbwq assertion failed");

// next-cycle implication
`define PBWQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pbwq assertion failed");

`endif

// ===== rtl/pbwq_pkg.sv =====
// Shared types and constants for the priority bucketed waiter queue.
// No dependencies; imported by pbwq_ctrl, pbwq_dp and the top level.
`default_nettype none

package pbwq_pkg;

    localparam int LEVELS = 8;
    localparam int SLOTS  = 16;

    // fixed field widths
    localparam int SLOT_W = 4;
    localparam int LVL_W  = 3;
    localparam int OP_W   = 2;
    localparam int STS_W  = 2;

    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd1;
    localparam logic [OP_W-1:0] OP_REM  = 2'd2;

    localparam logic [STS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STS_EMPTY    = 2'd1;
    localparam logic [STS_W-1:0] STS_CONFLICT = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_HEAD
    } t_state;

    typedef struct packed {
        logic capture;  // latch request, look up level
        logic exec;     // update links and bucket ends
        logic finish;   // find head, load result register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free; // result register can take a new result
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/priority_bucketed_waiter_queue.sv =====
// Priority bucketed waiter queue: one linked FIFO of waiter slots per level.
// Request channel s_axis (tuser = opcode; tdata = slot, priority), result
// channel m_axis (tdata = status, head slot, empty flag), and a one-bit
// fifo_mode config write channel (always ready; write only while idle).
// Every request gives exactly one result, in request order. Opcode enqueue
// appends the slot to its level, peek reports the head, remove unlinks the
// slot; misuse is reported in the status field and leaves the state alone.
// A request is captured, the links and bucket ends are updated, and then the
// head search loads the result register; the next request is taken while the
// head search runs, provided the result register is free for the new result.
// A stalled result holds in the output register; the block takes one more
// request, works on it, and then waits until the result has been taken.
// Reset (synchronous, active low) empties every bucket, clears fifo_mode
// and drops any pending result; no clearing pass, ready the cycle after.
// Depends on pbwq_pkg, pbwq_ctrl and pbwq_dp.
`default_nettype none

module priority_bucketed_waiter_queue (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // [3:0] waiter_slot, [6:4] waiter_priority, [7] zero
    input  wire  [1:0] s_axis_tuser,   // [1:0] opcode
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [1:0] status, [5:2] head_slot, [6] queue_empty, [7] 0
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire        i_cfg_data      // fifo_mode
);
    import pbwq_pkg::*;

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [STS_W-1:0]  status;
    logic [SLOT_W-1:0] head_slot;
    logic              queue_empty;

    assign o_cfg_ready = 1'b1;

    pbwq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pbwq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_fifo_mode (i_cfg_data),
        .i_opcode        (s_axis_tuser),
        .i_slot          (s_axis_tdata[3:0]),
        .i_priority      (s_axis_tdata[6:4]),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_status        (status),
        .o_head_slot     (head_slot),
        .o_queue_empty   (queue_empty)
    );

    assign m_axis_tdata = {1'b0, queue_empty, head_slot, status};

endmodule

`default_nettype wire

// ===== rtl/pbwq_ctrl.sv =====
// Sequencer for the waiter queue: capture, update, head search.
// Depends on pbwq_pkg and the assertion macro header.
`default_nettype none

`include "priority_bucketed_waiter_queue_defines.svh"

module pbwq_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_req_valid,
    output logic                  o_req_ready,
    input  wire pbwq_pkg::t_dp_sts i_sts,
    output pbwq_pkg::t_dp_cmd     o_cmd
);
    import pbwq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_HEAD;
            end
            S_HEAD: begin
                // next request overlaps the head search once the result can leave
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    o_req_ready  = 1'b1;
                    if (i_req_valid) begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_EXEC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `PBWQ_ASSERT_NEXT(a_accept_to_exec, i_req_valid && o_req_ready, r_state == S_EXEC)
    `PBWQ_ASSERT_NEXT(a_exec_to_head, r_state == S_EXEC, r_state == S_HEAD)
    `PBWQ_ASSERT_NOW(a_idle_ready, r_state == S_IDLE, o_req_ready)

endmodule

`default_nettype wire

// ===== rtl/pbwq_dp.sv =====
// Datapath: per-slot links, per-level bucket ends, head search, result register.
// Depends on pbwq_pkg and the assertion macro header.
`default_nettype none

`include "priority_bucketed_waiter_queue_defines.svh"

module pbwq_dp (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire pbwq_pkg::t_dp_cmd          i_cmd,
    output pbwq_pkg::t_dp_sts               o_sts,
    input  wire                             i_cfg_we,
    input  wire                             i_cfg_fifo_mode,
    input  wire [pbwq_pkg::OP_W-1:0]        i_opcode,
    input  wire [pbwq_pkg::SLOT_W-1:0]      i_slot,
    input  wire [pbwq_pkg::LVL_W-1:0]       i_priority,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [pbwq_pkg::STS_W-1:0]      o_status,
    output logic [pbwq_pkg::SLOT_W-1:0]     o_head_slot,
    output logic                            o_queue_empty
);
    import pbwq_pkg::*;

    logic                r_fifo_mode;

    logic [SLOT_W-1:0]   r_next  [SLOTS];
    logic [SLOT_W-1:0]   r_prev  [SLOTS];
    logic [LVL_W-1:0]    r_level [SLOTS];
    logic [SLOTS-1:0]    r_queued;
    logic [SLOT_W-1:0]   r_head  [LEVELS];
    logic [SLOT_W-1:0]   r_tail  [LEVELS];
    logic [LEVELS-1:0]   r_nonempty;

    logic [OP_W-1:0]     r_op;
    logic [SLOT_W-1:0]   r_slot;
    logic [LVL_W-1:0]    r_lv;
    logic [LVL_W-1:0]    n_lv;
    logic [STS_W-1:0]    r_status;

    logic                r_out_valid;
    logic [STS_W-1:0]    r_out_status;
    logic [SLOT_W-1:0]   r_out_head;
    logic                r_out_empty;

    // capture: level of the request
    always_comb begin
        if (i_opcode == OP_ENQ) begin
            if (r_fifo_mode) begin
                n_lv = '0;
            end else if (32'(i_priority) >= LEVELS) begin
                n_lv = LVL_W'(LEVELS - 1);
            end else begin
                n_lv = i_priority;
            end
        end else begin
            n_lv = r_level[i_slot];
        end
    end

    // exec: lookups at the latched slot and level
    logic              slot_ok;
    logic              is_queued;
    logic              lv_used;
    logic [SLOT_W-1:0] lv_head;
    logic [SLOT_W-1:0] lv_tail;
    logic [SLOT_W-1:0] s_next;
    logic [SLOT_W-1:0] s_prev;
    logic              do_enq;
    logic              do_rem;
    logic              conflict;

    always_comb begin
        slot_ok   = 32'(r_slot) < SLOTS;
        is_queued = r_queued[r_slot];
        lv_used   = r_nonempty[r_lv];
        lv_head   = r_head[r_lv];
        lv_tail   = r_tail[r_lv];
        s_next    = r_next[r_slot];
        s_prev    = r_prev[r_slot];
        do_enq    = i_cmd.exec && (r_op == OP_ENQ) && slot_ok && !is_queued;
        do_rem    = i_cmd.exec && (r_op == OP_REM) && slot_ok && is_queued;
        conflict  = ((r_op == OP_ENQ) && (!slot_ok || is_queued)) ||
                    ((r_op == OP_REM) && (!slot_ok || !is_queued));
    end

    // link arrays, one write per array per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_slot <= i_slot;
            r_lv   <= n_lv;
        end
        if (i_cmd.exec) begin
            r_status <= conflict ? STS_CONFLICT : STS_OK;
        end
        if (do_enq) begin
            if (lv_used) begin
                r_next[lv_tail] <= r_slot;
                r_prev[r_slot]  <= lv_tail;
            end else begin
                r_head[r_lv] <= r_slot;
            end
            r_tail[r_lv]    <= r_slot;
            r_level[r_slot] <= r_lv;
        end
        if (do_rem) begin
            if (lv_head == r_slot && lv_tail == r_slot) begin
                // last waiter of the bucket: only the queued and nonempty bits change
            end else if (lv_head == r_slot) begin
                r_head[r_lv] <= s_next;
            end else if (lv_tail == r_slot) begin
                r_tail[r_lv] <= s_prev;
            end else begin
                r_next[s_prev] <= s_next;
                r_prev[s_next] <= s_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued    <= '0;
            r_nonempty  <= '0;
            r_fifo_mode <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fifo_mode <= i_cfg_fifo_mode;
            end
            if (do_enq) begin
                r_queued[r_slot] <= 1'b1;
                r_nonempty[r_lv] <= 1'b1;
            end
            if (do_rem) begin
                r_queued[r_slot] <= 1'b0;
                if (lv_head == r_slot && lv_tail == r_slot) begin
                    r_nonempty[r_lv] <= 1'b0;
                end
            end
        end
    end

    // head search over the bucket flags
    logic [LVL_W-1:0]  top_lv;
    logic              any_used;
    logic [SLOT_W-1:0] top_head;

    always_comb begin
        top_lv = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (r_nonempty[i]) begin
                top_lv = LVL_W'(i);
            end
        end
        any_used = |r_nonempty;
        top_head = any_used ? r_head[top_lv] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_status <= ((r_op == OP_PEEK) && !any_used) ? STS_EMPTY : r_status;
            r_out_head   <= top_head;
            r_out_empty  <= !any_used;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_head_slot    = r_out_head;
    assign o_queue_empty  = r_out_empty;

    `PBWQ_ASSERT_NOW(a_empty_means_none_queued, r_nonempty == '0, r_queued == '0)
    `PBWQ_ASSERT_NOW(a_empty_head_zero, r_out_valid && r_out_empty, r_out_head == '0)
    `PBWQ_ASSERT_NEXT(a_finish_loads_result, i_cmd.finish, r_out_valid)

endmodule

`default_nettype wire

// ===== tb/sv/priority_bucketed_waiter_queue_tb.sv =====
// Self-checking testbench for priority_bucketed_waiter_queue: per-level waiter FIFOs.
// Drives enqueue/peek/remove requests and fifo_mode writes, predicts every result.
// Depends on pbwq_pkg and the priority_bucketed_waiter_queue RTL.
`timescale 1ns / 1ps

module priority_bucketed_waiter_queue_tb;
    import pbwq_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int STALL_CYCLES = 250;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 250;

    typedef struct {
        logic [STS_W-1:0]  status;
        logic [SLOT_W-1:0] head_slot;
        logic              queue_empty;
    } t_waiter_result;

    // Tracks the linked buckets and holds the results still owed by the block.
    class t_waiter_scoreboard;
        bit [SLOT_W-1:0] link_next[SLOTS];
        bit [SLOT_W-1:0] link_prev[SLOTS];
        bit [LVL_W-1:0]  level_of[SLOTS];
        bit              queued[SLOTS];
        bit [SLOT_W-1:0] bucket_first[LEVELS];
        bit [SLOT_W-1:0] bucket_last[LEVELS];
        bit [LEVELS-1:0] level_busy;
        bit              arrival_only;
        t_waiter_result  owed_results[$];
        int              errors;

        function void set_mode(bit mode);
            arrival_only = mode;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function int queued_count();
            int n;
            n = 0;
            for (int i = 0; i < SLOTS; i++) n += int'(queued[i]);
            return n;
        endfunction

        // random slot whose queued bit equals want; caller makes sure one exists
        function logic [SLOT_W-1:0] pick_slot(bit want);
            logic [SLOT_W-1:0] idx;
            idx = SLOT_W'($urandom_range(0, SLOTS - 1));
            for (int k = 0; k < SLOTS; k++) begin
                if (queued[idx] == want) return idx;
                idx = idx + 1'b1;
            end
            return idx;
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            $display("%0t ns mismatch %s: got %0d, expected %0d", $time, what, got, want);
        endtask

        function void note_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                   logic [LVL_W-1:0] pri);
            t_waiter_result r;
            logic [LVL_W-1:0] lv;
            logic [SLOT_W-1:0] first, last;
            r.status = STS_OK;
            if (op == OP_ENQ) begin
                if (queued[slot]) begin
                    r.status = STS_CONFLICT;
                end else begin
                    lv = arrival_only ? '0 : pri;
                    if (level_busy[lv]) begin
                        link_next[bucket_last[lv]] = slot;
                        link_prev[slot] = bucket_last[lv];
                    end else begin
                        bucket_first[lv] = slot;
                        link_prev[slot] = '0;
                        level_busy[lv] = 1'b1;
                    end
                    bucket_last[lv] = slot;
                    link_next[slot] = '0;
                    level_of[slot] = lv;
                    queued[slot] = 1'b1;
                end
            end else if (op == OP_REM) begin
                if (!queued[slot]) begin
                    r.status = STS_CONFLICT;
                end else begin
                    lv = level_of[slot];
                    first = bucket_first[lv];
                    last = bucket_last[lv];
                    if (first == slot && last == slot) begin
                        level_busy[lv] = 1'b0;
                    end else if (first == slot) begin
                        bucket_first[lv] = link_next[slot];
                    end else if (last == slot) begin
                        bucket_last[lv] = link_prev[slot];
                    end else begin
                        link_next[link_prev[slot]] = link_next[slot];
                        link_prev[link_next[slot]] = link_prev[slot];
                    end
                    queued[slot] = 1'b0;
                end
            end
            // highest busy level wins
            r.head_slot = '0;
            r.queue_empty = 1'b1;
            for (int i = LEVELS - 1; i >= 0; i--) begin
                if (level_busy[i] && r.queue_empty) begin
                    r.head_slot = bucket_first[i];
                    r.queue_empty = 1'b0;
                end
            end
            if (op == OP_PEEK && r.queue_empty) r.status = STS_EMPTY;
            owed_results = {owed_results, r};
        endfunction

        task check_result(logic [7:0] data);
            t_waiter_result want;
            if (owed_results.size() == 0) begin
                report_mismatch("result with nothing owed, tdata", int'(data), 0);
                return;
            end
            want = owed_results.pop_front();
            if (data[1:0] !== want.status)
                report_mismatch("status", int'(data[1:0]), int'(want.status));
            if (data[5:2] !== want.head_slot)
                report_mismatch("head_slot", int'(data[5:2]), int'(want.head_slot));
            if (data[6] !== want.queue_empty)
                report_mismatch("queue_empty", int'(data[6]), int'(want.queue_empty));
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    wire        s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    wire        m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    wire  [7:0] m_axis_tdata;
    logic       i_cfg_valid = 1'b0;
    wire        o_cfg_ready;
    logic       i_cfg_data = 1'b0;

    t_waiter_scoreboard sb = new();

    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int stall_requests = 0;
    int cycle_count = 0;

    priority_bucketed_waiter_queue DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // requests and results are both seen here, so their order in one edge is fixed
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[6:4]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // result side back-pressure, with long hold-offs on demand
    initial begin : result_sink
        int stalls_served;
        int stall_left;
        stalls_served = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stalls_served != stall_requests) begin
                stalls_served = stall_requests;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = rx_calm || ($urandom_range(0, 99) >= 29);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[priority_bucketed_waiter_queue] ERROR");
        $finish;
    end

    // all tasks below start and end just after a falling edge
    task automatic send_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                logic [LVL_W-1:0] pri);
        while (!tx_calm && $urandom_range(0, 99) < 29) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = op;
        s_axis_tdata = {1'b0, pri, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_fifo_mode(bit mode);
        i_cfg_valid = 1'b1;
        i_cfg_data = mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_mode(mode);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // well-formed traffic steered toward a fill target, with some noise
    task automatic random_request(int target);
        logic [OP_W-1:0] op;
        logic [SLOT_W-1:0] slot;
        logic [LVL_W-1:0] pri;
        int n;
        int roll;
        bit grow;
        n = sb.queued_count();
        roll = $urandom_range(0, 99);
        pri = LVL_W'($urandom_range(0, LEVELS - 1));
        slot = SLOT_W'($urandom_range(0, SLOTS - 1));
        if (roll < 6) begin
            op = OP_W'($urandom_range(0, 3));
        end else if (roll < 20) begin
            op = OP_PEEK;
        end else begin
            grow = (n < target) ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) < 2);
            if (n == 0) grow = 1'b1;
            if (n == SLOTS) grow = 1'b0;
            op = grow ? OP_ENQ : OP_REM;
            slot = sb.pick_slot(!grow);
        end
        send_request(op, slot, pri);
    endtask

    initial begin : stimulus
        int target;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        write_fifo_mode(1'b0);
        send_request(OP_PEEK, 4'd0, 3'd0);         // peek on empty queue
        send_request(OP_REM, 4'd5, 3'd0);          // remove of idle slot
        send_request(OP_RESERVED, 4'd15, 3'd7);
        send_request(OP_ENQ, 4'd0, 3'd0);
        send_request(OP_ENQ, 4'd15, 3'd7);
        send_request(OP_ENQ, 4'd3, 3'd7);
        send_request(OP_ENQ, 4'd0, 3'd3);          // already queued
        send_request(OP_ENQ, 4'd9, 3'd7);
        send_request(OP_PEEK, 4'd0, 3'd0);
        send_request(OP_REM, 4'd3, 3'd0);          // middle of bucket
        send_request(OP_REM, 4'd9, 3'd0);          // tail
        send_request(OP_REM, 4'd15, 3'd0);         // sole entry
        send_request(OP_ENQ, 4'd10, 3'd5);
        send_request(OP_ENQ, 4'd11, 3'd5);
        send_request(OP_ENQ, 4'd12, 3'd5);
        send_request(OP_REM, 4'd10, 3'd0);         // head
        send_request(OP_PEEK, 4'd0, 3'd0);
        send_request(OP_REM, 4'd12, 3'd0);
        send_request(OP_REM, 4'd11, 3'd0);
        send_request(OP_ENQ, 4'd6, 3'd2);
        send_request(OP_REM, 4'd0, 3'd0);
        wait_drained();
        // switch to arrival order with a waiter still in bucket 2
        write_fifo_mode(1'b1);
        send_request(OP_ENQ, 4'd1, 3'd7);
        send_request(OP_ENQ, 4'd2, 3'd0);
        send_request(OP_PEEK, 4'd0, 3'd0);
        send_request(OP_REM, 4'd6, 3'd0);
        send_request(OP_PEEK, 4'd0, 3'd0);
        send_request(OP_REM, 4'd1, 3'd0);
        send_request(OP_REM, 4'd2, 3'd0);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            write_fifo_mode(p[0]);
            tx_calm = (p == 1 || p == 2);
            rx_calm = (p == 1);
            if (p == 2) stall_requests++;
            target = 3;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 40 == 0) target = (target == 3) ? SLOTS : 3;
                if (p == 2 && i == 60) tx_calm = 1'b0;
                if (p == 3 && i == PHASE_ITEMS / 2) wait_drained();
                random_request(target);
            end
            wait_drained();
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        repeat (10) @(negedge i_clk);
        if (sb.errors == 0)
            $display("[priority_bucketed_waiter_queue] OK");
        else
            $display("[priority_bucketed_waiter_queue] ERROR");
        $finish;
    end

endmodule
